// ===== src/gda_pkg.sv =====
// shared types, constants and calendar helpers for the gregorian date arithmetic block
// no dependencies

package gda_pkg;

    localparam int OP_W     = 2;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 23;
    localparam int ORDER_W  = 2;
    localparam int K_W      = 3;

    localparam int YEAR_MAX_DEF = 9999;

    localparam int DAYS_1Y   = 365;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_400Y = 146097;

    localparam int DIFF_MAX = 4194303;
    localparam int DIFF_MIN = -4194304;

    // exact floor(x / 25) for x below 2**14
    localparam int RECIP_25 = 20972;
    localparam int RECIP_W  = 15;
    localparam int RECIP_SH = 19;

    typedef enum logic [OP_W-1:0] {
        OP_SHIFT = 2'd0,
        OP_DIFF  = 2'd1,
        OP_CMP   = 2'd2
    } t_op;

    typedef enum logic [ORDER_W-1:0] {
        ORD_BEFORE = 2'd0,
        ORD_EQUAL  = 2'd1,
        ORD_AFTER  = 2'd2
    } t_order;

    typedef enum logic [1:0] {
        PH_400 = 2'd0,
        PH_100 = 2'd1,
        PH_4   = 2'd2,
        PH_1   = 2'd3
    } t_phase;

    typedef struct packed {
        logic           load;
        logic           sel_b;
        logic           ymul;
        logic           ydiv;
        logic           dnum;
        logic           exec;
        logic           dstep;
        t_phase         phase;
        logic [K_W-1:0] k;
        logic           mstep;
        logic           out_load;
    } t_cmd;

    typedef struct packed {
        logic conv;
        logic mdone;
    } t_sts;

    function automatic int f_days_before_year(input int y);
        int p;
        p = y - 1;
        return DAYS_1Y * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic int f_top_day(input int ym);
        return f_days_before_year(ym + 1) - 1;
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the year before the first of month m
    function automatic logic [8:0] f_cum_days(input logic [3:0] m);
        logic [8:0] c;
        unique case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [17:0] f_div_base(input t_phase ph);
        logic [17:0] b;
        unique case (ph)
            PH_400:  b = 18'(DAYS_400Y);
            PH_100:  b = 18'(DAYS_100Y);
            PH_4:    b = 18'(DAYS_4Y);
            default: b = 18'(DAYS_1Y);
        endcase
        return b;
    endfunction

    function automatic logic [8:0] f_year_wt(input t_phase ph);
        logic [8:0] w;
        unique case (ph)
            PH_400:  w = 9'd400;
            PH_100:  w = 9'd100;
            PH_4:    w = 9'd4;
            default: w = 9'd1;
        endcase
        return w;
    endfunction

endpackage

// ===== src/gregorian_date_arithmetic_core.sv =====
// difference, compare, an unused op code and an out-of-range shift go from the accepted beat
// to the result beat without the date rebuild; a shift in range adds the 400-year divide (one
// cycle per quotient bit, 5 bits at the default year limit), the century, 4-year and year steps
// and the month walk; one item at a time, the next beat taken once the result
// sits in the output register. synchronous active-low reset clears the controller and the
// output valid; the datapath registers are not reset

module gregorian_date_arithmetic_core #(
    parameter int YEAR_MAX = gda_pkg::YEAR_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic        [gda_pkg::OP_W-1:0]     i_op,
    input  logic        [gda_pkg::YEAR_W-1:0]   i_year_a,
    input  logic        [gda_pkg::MONTH_W-1:0]  i_month_a,
    input  logic        [gda_pkg::DAY_W-1:0]    i_day_a,
    input  logic        [gda_pkg::YEAR_W-1:0]   i_year_b,
    input  logic        [gda_pkg::MONTH_W-1:0]  i_month_b,
    input  logic        [gda_pkg::DAY_W-1:0]    i_day_b,
    input  logic signed [gda_pkg::OFFSET_W-1:0] i_offset,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic        [gda_pkg::YEAR_W-1:0]   o_res_year,
    output logic        [gda_pkg::MONTH_W-1:0]  o_res_month,
    output logic        [gda_pkg::DAY_W-1:0]    o_res_day,
    output logic signed [gda_pkg::OFFSET_W-1:0] o_day_diff,
    output logic        [gda_pkg::ORDER_W-1:0]  o_order,
    output logic                                o_range_error
);
    import gda_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gda_ctrl #(
        .YEAR_MAX (YEAR_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gda_datapath #(
        .YEAR_MAX (YEAR_MAX)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_year_a      (i_year_a),
        .i_month_a     (i_month_a),
        .i_day_a       (i_day_a),
        .i_year_b      (i_year_b),
        .i_month_b     (i_month_b),
        .i_day_b       (i_day_b),
        .i_offset      (i_offset),
        .o_res_year    (o_res_year),
        .o_res_month   (o_res_month),
        .o_res_day     (o_res_day),
        .o_day_diff    (o_day_diff),
        .o_order       (o_order),
        .o_range_error (o_range_error)
    );

endmodule

// ===== src/gda_ctrl.sv =====
// controller state machine: sequences day numbering, the operation and the date rebuild
// depends on gda_pkg

module gda_ctrl #(
    parameter int YEAR_MAX = gda_pkg::YEAR_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  gda_pkg::t_sts i_sts,
    output gda_pkg::t_cmd o_cmd
);
    import gda_pkg::*;

    localparam int Q_W = $clog2(YEAR_MAX / 400 + 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'h001,
        ST_YMUL  = 11'h002,
        ST_YDIV  = 11'h004,
        ST_DNUM  = 11'h008,
        ST_EXEC  = 11'h010,
        ST_D400  = 11'h020,
        ST_D100  = 11'h040,
        ST_D4    = 11'h080,
        ST_D1    = 11'h100,
        ST_MONTH = 11'h200,
        ST_DONE  = 11'h400
    } t_state;

    t_state         r_state, n_state;
    logic [K_W-1:0] r_k, n_k;
    logic           r_sel_b, n_sel_b;
    logic           r_out_valid, n_out_valid;
    t_cmd           cmd;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_sel_b     = r_sel_b;
        cmd         = '0;
        cmd.sel_b   = r_sel_b;
        cmd.k       = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_sel_b  = 1'b0;
                    n_state  = ST_YMUL;
                end
            end
            ST_YMUL: begin
                cmd.ymul = 1'b1;
                n_state  = ST_YDIV;
            end
            ST_YDIV: begin
                cmd.ydiv = 1'b1;
                n_state  = ST_DNUM;
            end
            ST_DNUM: begin
                cmd.dnum = 1'b1;
                if (r_sel_b) begin
                    n_state = ST_EXEC;
                end else begin
                    n_sel_b = 1'b1;
                    n_state = ST_YMUL;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                n_k      = K_W'(Q_W - 1);
                n_state  = i_sts.conv ? ST_D400 : ST_DONE;
            end
            ST_D400: begin
                cmd.dstep = 1'b1;
                cmd.phase = PH_400;
                if (r_k == '0) begin
                    n_k     = K_W'(1);
                    n_state = ST_D100;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            ST_D100: begin
                cmd.dstep = 1'b1;
                cmd.phase = PH_100;
                if (r_k == '0) begin
                    n_k     = K_W'(4);
                    n_state = ST_D4;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            ST_D4: begin
                cmd.dstep = 1'b1;
                cmd.phase = PH_4;
                if (r_k == '0) begin
                    n_k     = K_W'(1);
                    n_state = ST_D1;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            ST_D1: begin
                cmd.dstep = 1'b1;
                cmd.phase = PH_1;
                if (r_k == '0) begin
                    n_state = ST_MONTH;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            ST_MONTH: begin
                cmd.mstep = 1'b1;
                if (i_sts.mdone) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_sel_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_sel_b     <= n_sel_b;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== src/gda_datapath.sv =====
// datapath: input capture, date clamp and day numbering, operation, date rebuild, result beat
// depends on gda_pkg

module gda_datapath #(
    parameter int YEAR_MAX = gda_pkg::YEAR_MAX_DEF
) (
    input  logic                                i_clk,
    input  gda_pkg::t_cmd                       i_cmd,
    output gda_pkg::t_sts                       o_sts,
    input  logic        [gda_pkg::OP_W-1:0]     i_op,
    input  logic        [gda_pkg::YEAR_W-1:0]   i_year_a,
    input  logic        [gda_pkg::MONTH_W-1:0]  i_month_a,
    input  logic        [gda_pkg::DAY_W-1:0]    i_day_a,
    input  logic        [gda_pkg::YEAR_W-1:0]   i_year_b,
    input  logic        [gda_pkg::MONTH_W-1:0]  i_month_b,
    input  logic        [gda_pkg::DAY_W-1:0]    i_day_b,
    input  logic signed [gda_pkg::OFFSET_W-1:0] i_offset,
    output logic        [gda_pkg::YEAR_W-1:0]   o_res_year,
    output logic        [gda_pkg::MONTH_W-1:0]  o_res_month,
    output logic        [gda_pkg::DAY_W-1:0]    o_res_day,
    output logic signed [gda_pkg::OFFSET_W-1:0] o_day_diff,
    output logic        [gda_pkg::ORDER_W-1:0]  o_order,
    output logic                                o_range_error
);
    import gda_pkg::*;

    localparam int YW   = $clog2(YEAR_MAX + 1);
    localparam int TOP  = f_top_day(YEAR_MAX);
    localparam int DN_W = $clog2(TOP + 1);
    localparam int DN1  = DN_W + 1;
    localparam int CW   = DN_W + 1;
    localparam int TW   = ((DN_W + 1 > OFFSET_W) ? DN_W + 1 : OFFSET_W) + 1;
    localparam int DW   = (DN_W + 1 > OFFSET_W + 1) ? DN_W + 1 : OFFSET_W + 1;
    localparam int PR_W = YW - 2 + RECIP_W;
    localparam int QY_W = PR_W - RECIP_SH;

    localparam logic signed [TW-1:0] TOP_S  = TW'(TOP);
    localparam logic signed [DW-1:0] DMAX_S = DW'(DIFF_MAX);
    localparam logic signed [DW-1:0] DMIN_S = DW'(DIFF_MIN);

    // captured item
    logic        [OP_W-1:0]     r_op;
    logic        [YEAR_W-1:0]   r_year_a, r_year_b;
    logic        [MONTH_W-1:0]  r_month_a, r_month_b;
    logic        [DAY_W-1:0]    r_day_a, r_day_b;
    logic signed [OFFSET_W-1:0] r_offset;

    // day numbering
    logic [YW-1:0]      r_y, r_p;
    logic [PR_W-1:0]    r_prod;
    logic [DN_W-1:0]    r_dby, r_na, r_nb;
    logic [8:0]         r_mpre;
    logic [YW-1:0]      r_ya;
    logic [MONTH_W-1:0] r_ma;
    logic [DAY_W-1:0]   r_da;

    // operation
    logic                       r_err;
    logic signed [OFFSET_W-1:0] r_diff;
    logic [ORDER_W-1:0]         r_ord;

    // date rebuild
    logic [CW-1:0]      r_rem;
    logic [YW-1:0]      r_cyear;
    logic [MONTH_W-1:0] r_cmon;
    logic [1:0]         r_n100, r_n1;
    logic [4:0]         r_n4;

    // result beat
    logic        [YEAR_W-1:0]   r_o_year, n_o_year;
    logic        [MONTH_W-1:0]  r_o_month, n_o_month;
    logic        [DAY_W-1:0]    r_o_day, n_o_day;
    logic signed [OFFSET_W-1:0] r_o_diff, n_o_diff;
    logic        [ORDER_W-1:0]  r_o_order, n_o_order;
    logic                       r_o_err, n_o_err;

    logic [YEAR_W-1:0]  y_in;
    logic [MONTH_W-1:0] m_in;
    logic [DAY_W-1:0]   d_in;
    logic [YW-1:0]      yc, pc;
    logic [QY_W-1:0]    q;
    logic [YW-1:0]      r100;
    logic               leap;
    logic [DN1-1:0]     dby_w;
    logic [MONTH_W-1:0] mc;
    logic [DAY_W-1:0]   dim, dc;
    logic [8:0]         mpre_w;

    logic signed [TW-1:0]       t_w;
    logic                       inr;
    logic signed [DW-1:0]       diff_w;
    logic signed [OFFSET_W-1:0] diff_sat;
    logic [ORDER_W-1:0]         ord_w;

    logic [CW-1:0]      div_w;
    logic [YW-1:0]      wt_w;
    logic               take;
    logic               leap_c;
    logic [DAY_W-1:0]   dimc;
    logic               mdone;
    logic               conv_ok;

    // year clamp and reciprocal product
    always_comb begin
        y_in = i_cmd.sel_b ? r_year_b : r_year_a;
        m_in = i_cmd.sel_b ? r_month_b : r_month_a;
        d_in = i_cmd.sel_b ? r_day_b : r_day_a;
        if (y_in == '0) begin
            yc = YW'(1);
        end else if (32'(y_in) > 32'(YEAR_MAX)) begin
            yc = YW'(YEAR_MAX);
        end else begin
            yc = YW'(y_in);
        end
        pc = yc - YW'(1);
    end

    // leap test, days before the year, month and day clamp
    always_comb begin
        q     = r_prod[PR_W-1:RECIP_SH];
        r100  = r_p - YW'(q) * YW'(100);
        leap  = (r_p[1:0] == 2'd3) && ((r100 != YW'(99)) || (q[1:0] == 2'd3));
        dby_w = DN1'(r_p) * DN1'(DAYS_1Y) + DN1'(r_p >> 2) - DN1'(q) + DN1'(q >> 2);
        if (m_in == '0) begin
            mc = MONTH_W'(1);
        end else if (m_in > MONTH_W'(12)) begin
            mc = MONTH_W'(12);
        end else begin
            mc = m_in;
        end
        dim = f_month_len(mc) + DAY_W'(leap && (mc == MONTH_W'(2)));
        if (d_in == '0) begin
            dc = DAY_W'(1);
        end else if (d_in > dim) begin
            dc = dim;
        end else begin
            dc = d_in;
        end
        mpre_w = f_cum_days(mc) + 9'(leap && (mc > MONTH_W'(2))) + 9'(dc) - 9'd1;
    end

    // shift target, difference and order
    always_comb begin
        t_w    = $signed(TW'(r_na)) + TW'(r_offset);
        inr    = (t_w >= 0) && (t_w <= TOP_S);
        diff_w = $signed(DW'(r_na)) - $signed(DW'(r_nb));
        if (diff_w > DMAX_S) begin
            diff_sat = OFFSET_W'(DIFF_MAX);
        end else if (diff_w < DMIN_S) begin
            diff_sat = OFFSET_W'(DIFF_MIN);
        end else begin
            diff_sat = OFFSET_W'(diff_w);
        end
        if (r_na < r_nb) begin
            ord_w = ORD_BEFORE;
        end else if (r_na == r_nb) begin
            ord_w = ORD_EQUAL;
        end else begin
            ord_w = ORD_AFTER;
        end
        conv_ok = (r_op == OP_SHIFT) && inr;
    end

    // restoring divide step and month walk
    always_comb begin
        div_w  = CW'(f_div_base(i_cmd.phase)) << i_cmd.k;
        wt_w   = YW'(f_year_wt(i_cmd.phase)) << i_cmd.k;
        take   = (r_rem >= div_w);
        leap_c = (r_n1 == 2'd3) && ((r_n4 != 5'd24) || (r_n100 == 2'd3));
        dimc   = f_month_len(r_cmon) + DAY_W'(leap_c && (r_cmon == MONTH_W'(2)));
        mdone  = !((r_cmon < MONTH_W'(12)) && (r_rem >= CW'(dimc)));
    end

    // result beat fields
    always_comb begin
        n_o_year  = '0;
        n_o_month = '0;
        n_o_day   = '0;
        n_o_diff  = '0;
        n_o_order = '0;
        n_o_err   = 1'b0;
        case (r_op)
            OP_SHIFT: begin
                n_o_err = r_err;
                if (r_err) begin
                    n_o_year  = YEAR_W'(r_ya);
                    n_o_month = r_ma;
                    n_o_day   = r_da;
                end else begin
                    n_o_year  = YEAR_W'(r_cyear);
                    n_o_month = r_cmon;
                    n_o_day   = DAY_W'(r_rem) + DAY_W'(1);
                end
            end
            OP_DIFF:  n_o_diff  = r_diff;
            OP_CMP:   n_o_order = r_ord;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_year_a  <= i_year_a;
            r_month_a <= i_month_a;
            r_day_a   <= i_day_a;
            r_year_b  <= i_year_b;
            r_month_b <= i_month_b;
            r_day_b   <= i_day_b;
            r_offset  <= i_offset;
        end
        if (i_cmd.ymul) begin
            r_y    <= yc;
            r_p    <= pc;
            r_prod <= PR_W'(pc >> 2) * PR_W'(RECIP_25);
        end
        if (i_cmd.ydiv) begin
            r_dby  <= DN_W'(dby_w);
            r_mpre <= mpre_w;
            if (!i_cmd.sel_b) begin
                r_ya <= r_y;
                r_ma <= mc;
                r_da <= dc;
            end
        end
        if (i_cmd.dnum) begin
            if (i_cmd.sel_b) begin
                r_nb <= r_dby + DN_W'(r_mpre);
            end else begin
                r_na <= r_dby + DN_W'(r_mpre);
            end
        end
        if (i_cmd.exec) begin
            r_err   <= !inr;
            r_diff  <= diff_sat;
            r_ord   <= ord_w;
            r_rem   <= CW'(t_w);
            r_cyear <= YW'(1);
            r_cmon  <= MONTH_W'(1);
            r_n100  <= '0;
            r_n4    <= '0;
            r_n1    <= '0;
        end
        if (i_cmd.dstep && take) begin
            r_rem   <= r_rem - div_w;
            r_cyear <= r_cyear + wt_w;
            case (i_cmd.phase)
                PH_100:  r_n100[i_cmd.k[0]] <= 1'b1;
                PH_4:    r_n4[i_cmd.k]      <= 1'b1;
                PH_1:    r_n1[i_cmd.k[0]]   <= 1'b1;
                default: ;
            endcase
        end
        if (i_cmd.mstep && !mdone) begin
            r_rem  <= r_rem - CW'(dimc);
            r_cmon <= r_cmon + MONTH_W'(1);
        end
        if (i_cmd.out_load) begin
            r_o_year  <= n_o_year;
            r_o_month <= n_o_month;
            r_o_day   <= n_o_day;
            r_o_diff  <= n_o_diff;
            r_o_order <= n_o_order;
            r_o_err   <= n_o_err;
        end
    end

    assign o_sts.conv    = conv_ok;
    assign o_sts.mdone   = mdone;
    assign o_res_year    = r_o_year;
    assign o_res_month   = r_o_month;
    assign o_res_day     = r_o_day;
    assign o_day_diff    = r_o_diff;
    assign o_order       = r_o_order;
    assign o_range_error = r_o_err;

endmodule

// ===== bench/gregorian_date_arithmetic_core_tb.sv =====
// self-checking bench for gregorian_date_arithmetic_core: directed and random date beats,
// random idling on both channels, results checked against an in-bench calendar predictor
// depends on gda_pkg and the core itself

module gregorian_date_arithmetic_core_tb;

    import gda_pkg::*;

    localparam int YEAR_LIMIT    = YEAR_MAX_DEF;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_BEATS  = 650;
    localparam int FULL_SPAN     = 3652058;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [YEAR_W-1:0]          year_a;
        logic [MONTH_W-1:0]         month_a;
        logic [DAY_W-1:0]           day_a;
        logic [YEAR_W-1:0]          year_b;
        logic [MONTH_W-1:0]         month_b;
        logic [DAY_W-1:0]           day_b;
        logic signed [OFFSET_W-1:0] offset;
    } date_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]          res_year;
        logic [MONTH_W-1:0]         res_month;
        logic [DAY_W-1:0]           res_day;
        logic signed [OFFSET_W-1:0] day_diff;
        logic [ORDER_W-1:0]         order_code;
        logic                       range_err;
    } date_res_t;

    class date_scoreboard;
        date_res_t expected_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        static function bit leap_year(int y);
            return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
        endfunction

        static function int month_days(int y, int m);
            int len;
            case (m)
                4, 6, 9, 11: len = 30;
                2:           len = leap_year(y) ? 29 : 28;
                default:     len = 31;
            endcase
            return len;
        endfunction

        function int days_before(int y);
            int p;
            p = y - 1;
            return 365 * p + p / 4 - p / 100 + p / 400;
        endfunction

        function void saturate(input int y_in, input int m_in, input int d_in,
                               output int y, output int m, output int d);
            int len;
            y = y_in < 1 ? 1 : (y_in > YEAR_LIMIT ? YEAR_LIMIT : y_in);
            m = m_in < 1 ? 1 : (m_in > 12 ? 12 : m_in);
            len = month_days(y, m);
            d = d_in < 1 ? 1 : (d_in > len ? len : d_in);
        endfunction

        function int serial_day(int y, int m, int d);
            int n;
            n = days_before(y);
            for (int k = 1; k < m; k++)
                n += month_days(y, k);
            return n + d - 1;
        endfunction

        function void serial_to_date(input int n, output int y, output int m, output int d);
            int n400, n100, n4, n1, r;
            n400 = n / DAYS_400Y;
            r = n % DAYS_400Y;
            n100 = r / DAYS_100Y;
            if (n100 > 3) n100 = 3;
            r -= n100 * DAYS_100Y;
            n4 = r / DAYS_4Y;
            r = r % DAYS_4Y;
            n1 = r / 365;
            if (n1 > 3) n1 = 3;
            r -= n1 * 365;
            y = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
            m = 1;
            while (m < 12 && r >= month_days(y, m)) begin
                r -= month_days(y, m);
                m++;
            end
            d = r + 1;
        endfunction

        function void note_beat(date_req_t r);
            int ya, ma, da, yb, mb, db, na, nb, t, ry, rm, rd, span;
            date_res_t e;
            e = '0;
            saturate(r.year_a, r.month_a, r.day_a, ya, ma, da);
            saturate(r.year_b, r.month_b, r.day_b, yb, mb, db);
            na = serial_day(ya, ma, da);
            nb = serial_day(yb, mb, db);
            case (r.op)
                OP_SHIFT: begin
                    t = na + int'(r.offset);
                    ry = ya;
                    rm = ma;
                    rd = da;
                    if (t < 0 || t > days_before(YEAR_LIMIT + 1) - 1)
                        e.range_err = 1'b1;
                    else
                        serial_to_date(t, ry, rm, rd);
                    e.res_year  = YEAR_W'(ry);
                    e.res_month = MONTH_W'(rm);
                    e.res_day   = DAY_W'(rd);
                end
                OP_DIFF: begin
                    span = na - nb;
                    if (span > DIFF_MAX) span = DIFF_MAX;
                    if (span < DIFF_MIN) span = DIFF_MIN;
                    e.day_diff = OFFSET_W'(span);
                end
                OP_CMP: begin
                    e.order_code = (na < nb) ? ORD_BEFORE : (na == nb) ? ORD_EQUAL : ORD_AFTER;
                end
                default: ;
            endcase
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(date_res_t got);
            date_res_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none actual %p",
                         $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("res_year", e.res_year, got.res_year);
            compare_field("res_month", e.res_month, got.res_month);
            compare_field("res_day", e.res_day, got.res_day);
            compare_field("day_diff", e.day_diff, got.day_diff);
            compare_field("order", e.order_code, got.order_code);
            compare_field("range_error", e.range_err, got.range_err);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_op;
    logic [YEAR_W-1:0]          i_year_a;
    logic [MONTH_W-1:0]         i_month_a;
    logic [DAY_W-1:0]           i_day_a;
    logic [YEAR_W-1:0]          i_year_b;
    logic [MONTH_W-1:0]         i_month_b;
    logic [DAY_W-1:0]           i_day_b;
    logic signed [OFFSET_W-1:0] i_offset;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [YEAR_W-1:0]          o_res_year;
    logic [MONTH_W-1:0]         o_res_month;
    logic [DAY_W-1:0]           o_res_day;
    logic signed [OFFSET_W-1:0] o_day_diff;
    logic [ORDER_W-1:0]         o_order;
    logic                       o_range_error;

    date_scoreboard sb = new();
    bit             idle_on = 1'b0;
    int             stall_left = 0;
    int             quiet_cycles = 0;

    gregorian_date_arithmetic_core #(
        .YEAR_MAX(YEAR_LIMIT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_year_a     (i_year_a),
        .i_month_a    (i_month_a),
        .i_day_a      (i_day_a),
        .i_year_b     (i_year_b),
        .i_month_b    (i_month_b),
        .i_day_b      (i_day_b),
        .i_offset     (i_offset),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_res_year   (o_res_year),
        .o_res_month  (o_res_month),
        .o_res_day    (o_res_day),
        .o_day_diff   (o_day_diff),
        .o_order      (o_order),
        .o_range_error(o_range_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_beat('{i_op, i_year_a, i_month_a, i_day_a,
                           i_year_b, i_month_b, i_day_b, i_offset});
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat('{o_res_year, o_res_month, o_res_day,
                            o_day_diff, o_order, o_range_error});
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
                $display("gregorian_date_arithmetic_core_tb failed");
                $finish;
            end
        end
    end

    function automatic date_req_t mk(int op, int ya, int ma, int da,
                                     int yb, int mb, int db, int off);
        date_req_t r;
        r.op      = OP_W'(op);
        r.year_a  = YEAR_W'(ya);
        r.month_a = MONTH_W'(ma);
        r.day_a   = DAY_W'(da);
        r.year_b  = YEAR_W'(yb);
        r.month_b = MONTH_W'(mb);
        r.day_b   = DAY_W'(db);
        r.offset  = OFFSET_W'(off);
        return r;
    endfunction

    function automatic void rand_date(output int y, output int m, output int d);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end else begin
            case ($urandom_range(0, 9))
                0:       y = $urandom_range(1, 3);
                1:       y = $urandom_range(YEAR_LIMIT - 2, YEAR_LIMIT);
                2:       y = 100 * $urandom_range(1, 99);
                default: y = $urandom_range(1, YEAR_LIMIT);
            endcase
            m = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
                d = date_scoreboard::month_days(y, m);
            else
                d = $urandom_range(1, date_scoreboard::month_days(y, m));
        end
    endfunction

    function automatic date_req_t random_req();
        int op, ya, ma, da, yb, mb, db, off;
        op = $urandom_range(0, 15);
        op = (op == 0) ? int'(OP_UNUSED) : op % 3;
        rand_date(ya, ma, da);
        rand_date(yb, mb, db);
        // dates close together for difference and compare
        if (op != int'(OP_SHIFT) && $urandom_range(0, 3) == 0) begin
            yb = ya;
            mb = ma;
            db = da + $urandom_range(0, 2) - 1;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: off = $urandom_range(0, 40);
            4, 5:       off = $urandom_range(0, 1500);
            6, 7:       off = $urandom_range(0, 200000);
            8:          off = $urandom_range(0, 4194303);
            default:    off = $urandom_range(FULL_SPAN - 50000, FULL_SPAN);
        endcase
        if ($urandom_range(0, 1)) off = -off - ($urandom_range(0, 9) == 0 ? 1 : 0);
        return mk(op, ya, ma, da, yb, mb, db, off);
    endfunction

    task automatic drive_beat(date_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_op       <= r.op;
        i_year_a   <= r.year_a;
        i_month_a  <= r.month_a;
        i_day_a    <= r.day_a;
        i_year_b   <= r.year_b;
        i_month_b  <= r.month_b;
        i_day_b    <= r.day_b;
        i_offset   <= r.offset;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= '0;
        i_year_a   <= '0;
        i_month_a  <= '0;
        i_day_a    <= '0;
        i_year_b   <= '0;
        i_month_b  <= '0;
        i_day_b    <= '0;
        i_offset   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // range edges of the shift
        drive_beat(mk(OP_SHIFT, 1, 1, 1, 1, 1, 1, 0));
        drive_beat(mk(OP_SHIFT, 1, 1, 1, 1, 1, 1, -1));
        drive_beat(mk(OP_SHIFT, 9999, 12, 31, 1, 1, 1, 1));
        drive_beat(mk(OP_SHIFT, 1, 1, 1, 1, 1, 1, FULL_SPAN));
        drive_beat(mk(OP_SHIFT, 9999, 12, 31, 1, 1, 1, -FULL_SPAN));
        drive_beat(mk(OP_SHIFT, 5000, 6, 15, 1, 1, 1, 4194303));
        drive_beat(mk(OP_SHIFT, 5000, 6, 15, 1, 1, 1, -4194304));
        // leap february and year rollover
        drive_beat(mk(OP_SHIFT, 2000, 2, 28, 1, 1, 1, 1));
        drive_beat(mk(OP_SHIFT, 1900, 2, 28, 1, 1, 1, 1));
        drive_beat(mk(OP_SHIFT, 2024, 2, 29, 1, 1, 1, 365));
        drive_beat(mk(OP_SHIFT, 1999, 12, 31, 1, 1, 1, 1));
        drive_beat(mk(OP_SHIFT, 2400, 3, 1, 1, 1, 1, -1));
        // difference and compare extremes
        drive_beat(mk(OP_DIFF, 9999, 12, 31, 1, 1, 1, 0));
        drive_beat(mk(OP_DIFF, 1, 1, 1, 9999, 12, 31, 0));
        drive_beat(mk(OP_DIFF, 2000, 3, 1, 2000, 3, 1, 0));
        drive_beat(mk(OP_CMP, 1, 1, 1, 1, 1, 2, 0));
        drive_beat(mk(OP_CMP, 7777, 7, 7, 7777, 7, 7, 0));
        drive_beat(mk(OP_CMP, 9999, 12, 31, 9999, 12, 30, 0));
        drive_beat(mk(OP_UNUSED, 16383, 15, 31, 16383, 15, 31, -4194304));
        // out-of-range date fields saturate
        drive_beat(mk(OP_DIFF, 0, 0, 0, 16383, 15, 31, 0));
        drive_beat(mk(OP_SHIFT, 2023, 2, 31, 1, 1, 1, 0));
        drive_beat(mk(OP_SHIFT, 2000, 2, 30, 1, 1, 1, 0));
        drive_beat(mk(OP_CMP, 2023, 4, 31, 2023, 4, 30, 0));
        drive_beat(mk(OP_SHIFT, 10000, 13, 0, 0, 0, 0, 0));

        for (int k = 0; k < RANDOM_BEATS; k++) begin
            idle_on = (k < 200) || (k >= 320 && k < 550);
            drive_beat(random_req());
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("gregorian_date_arithmetic_core_tb passed");
        else
            $display("gregorian_date_arithmetic_core_tb failed");
        $finish;
    end

endmodule
